>>> hw/rtl/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types and constants of the greedy set cover engine: request and
// response words, item kinds, status codes, register indexes, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package gsc_pkg;

   // default sizes of the stores
   localparam int DEF_MAX_SETS        = 1024;
   localparam int DEF_MAX_ELEMENT_IDS = 4096;
   localparam int DEF_MAX_MEMBERS     = 16384;
   localparam int DEF_MAX_SCORE       = 255;

   // item kinds
   localparam logic [1:0] KIND_OPEN   = 2'd0;
   localparam logic [1:0] KIND_MEMBER = 2'd1;
   localparam logic [1:0] KIND_PICK   = 2'd2;

   // response status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_SET    = 3'd1;
   localparam logic [2:0] ST_BAD_ELEM   = 3'd2;
   localparam logic [2:0] ST_OVERFLOW   = 3'd3;
   localparam logic [2:0] ST_BAD_WEIGHT = 3'd4;
   localparam logic [2:0] ST_BAD_SCORE  = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_SCORE_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_SET_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_ELEM_LIMIT   = 2'd2;
   localparam logic [1:0] CSR_MEMBER_CAP   = 2'd3;

   // reset values of the configuration registers
   localparam logic [7:0]  RST_SCORE_LIMIT = 8'd255;
   localparam logic [9:0]  RST_SET_LIMIT   = 10'd1023;
   localparam logic [11:0] RST_ELEM_LIMIT  = 12'd4095;
   localparam logic [14:0] RST_MEMBER_CAP  = 15'd16384;

   // only legal membership weight
   localparam logic [7:0] UNIT_WEIGHT = 8'd1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  set_number;
      logic [7:0]  set_score;
      logic [11:0] element_number;
      logic [7:0]  member_weight;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [9:0] picked_set;
      logic       picked_valid;
      logic       cover_done;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/greedy_set_cover_engine_core.sv
// ----------------------------------------------------------------------------
// greedy_set_cover_engine_core
// Greedy set cover over bucket queues. Sets, memberships and occurrence lists
// live in synchronous memories; a sequencer walks them state by state.
// ----------------------------------------------------------------------------
//
//   channel | ports                         | direction | word
//   --------+-------------------------------+-----------+----------------------
//   request | req_valid req_ready req_data  | in        | gsc_pkg::req_type
//   result  | rsp_valid rsp_ready rsp_data  | out       | gsc_pkg::rsp_type
//   config  | csr_valid csr_ready csr_index | in        | 2-bit index, 16-bit
//           | csr_data                      |           | data
//
// Open items pass S_OPEN, then S_LINK if accepted onto a non-empty bucket;
// member items pass S_MEM, then S_MEM_LNK unless refused; kind 3 items go
// to S_RESULT. A pick scans bucket levels downward, walks the members of the
// picked set and moves each other set holding their elements a bucket down.
// After reset a clearing pass over max(MAX_SETS, MAX_ELEMENT_IDS, MAX_SCORE+1)
// addresses (4096 by default) clears bucket heads, set used flags and
// occurrence heads; requests wait for it. One request is worked at a time;
// a finished result waits in the output register while the next is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_set_cover_engine_core #(
   parameter int MAX_SETS        = gsc_pkg::DEF_MAX_SETS,
   parameter int MAX_ELEMENT_IDS = gsc_pkg::DEF_MAX_ELEMENT_IDS,
   parameter int MAX_MEMBERS     = gsc_pkg::DEF_MAX_MEMBERS,
   parameter int MAX_SCORE       = gsc_pkg::DEF_MAX_SCORE
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire gsc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output gsc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_data
);

   localparam int SW = $clog2(MAX_SETS);
   localparam int SL = SW + 1;
   localparam int EW = $clog2(MAX_ELEMENT_IDS);
   localparam int MW = $clog2(MAX_MEMBERS);
   localparam int ML = MW + 1;
   localparam int CW = $clog2(MAX_SCORE + 1);
   localparam int CLR_A = (MAX_SETS > MAX_ELEMENT_IDS) ? MAX_SETS : MAX_ELEMENT_IDS;
   localparam int CLR_DEPTH = (CLR_A > MAX_SCORE + 1) ? CLR_A : MAX_SCORE + 1;
   localparam int KW = $clog2(CLR_DEPTH);
   localparam logic [SL-1:0] SET_NIL = {SL{1'b1}};
   localparam logic [ML-1:0] MEM_NIL = {ML{1'b1}};

   typedef enum logic [18:0] {
      S_CLEAR    = 19'h00001,
      S_IDLE     = 19'h00002,
      S_OPEN     = 19'h00004,
      S_LINK     = 19'h00008,
      S_MEM      = 19'h00010,
      S_MEM_LNK  = 19'h00020,
      S_SCAN     = 19'h00040,
      S_SCAN_CHK = 19'h00080,
      S_UNP      = 19'h00100,
      S_UNL      = 19'h00200,
      S_PUSH     = 19'h00400,
      S_FIRST    = 19'h00800,
      S_M        = 19'h01000,
      S_M_RD     = 19'h02000,
      S_O_HEAD   = 19'h04000,
      S_O        = 19'h08000,
      S_O_CHK    = 19'h10000,
      S_O_NEXT   = 19'h20000,
      S_RESULT   = 19'h40000
   } state_type;

   // control and payload registers
   state_type         state_ff, state_in;
   logic [KW-1:0]     clr_ff, clr_in;
   logic [7:0]        score_limit_ff, score_limit_in;
   logic [9:0]        set_limit_ff, set_limit_in;
   logic [11:0]       elem_limit_ff, elem_limit_in;
   logic [14:0]       member_cap_ff, member_cap_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [SL-1:0]     open_ff, open_in;
   logic [ML-1:0]     fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   gsc_pkg::rsp_type  rsp_ff, rsp_in;
   gsc_pkg::rsp_type  res_ff, res_in;
   gsc_pkg::req_type  req_ff, req_in;
   logic [SW-1:0]     s_ff, s_in;
   logic [SW-1:0]     x_ff, x_in;
   logic [SL-1:0]     h_ff, h_in;
   logic [CW-1:0]     sc_ff, sc_in;
   logic [ML-1:0]     m_ff, m_in;
   logic [ML-1:0]     mn_ff, mn_in;
   logic [ML-1:0]     o_ff, o_in;
   logic [ML-1:0]     on_ff, on_in;
   logic              own_ff, own_in;
   logic              pick_ff, pick_in;

   // memories
   logic [SL-1:0] bh_mem     [MAX_SCORE+1];
   logic [SL-1:0] sprev_mem  [MAX_SETS];
   logic [SL-1:0] snext_mem  [MAX_SETS];
   logic [CW-1:0] sscore_mem [MAX_SETS];
   logic [ML-1:0] sfirst_mem [MAX_SETS];
   logic [ML-1:0] slast_mem  [MAX_SETS];
   logic          sused_mem  [MAX_SETS];
   logic [EW-1:0] melem_mem  [MAX_MEMBERS];
   logic [SL-1:0] mowner_mem [MAX_MEMBERS];
   logic [ML-1:0] mprev_mem  [MAX_MEMBERS];
   logic [ML-1:0] mnext_mem  [MAX_MEMBERS];
   logic [ML-1:0] onext_mem  [MAX_MEMBERS];
   logic [ML-1:0] ohead_mem  [MAX_ELEMENT_IDS];
   logic [ML-1:0] otail_mem  [MAX_ELEMENT_IDS];

   logic bh_we, sprev_we, snext_we, sscore_we, sfirst_we, slast_we, sused_we;
   logic melem_we, mowner_we, mprev_we, mnext_we, onext_we, ohead_we, otail_we;
   logic bh_re, sprev_re, snext_re, sscore_re, sfirst_re, slast_re, sused_re;
   logic melem_re, mowner_re, mprev_re, mnext_re, onext_re, ohead_re, otail_re;
   logic [CW-1:0] bh_wa, bh_ra;
   logic [SW-1:0] sprev_wa, snext_wa, sscore_wa, sfirst_wa, slast_wa, sused_wa;
   logic [SW-1:0] set_ra, sfirst_ra, slast_ra, sused_ra;
   logic [MW-1:0] melem_wa, mowner_wa, mprev_wa, mnext_wa, onext_wa;
   logic [MW-1:0] mem_ra, mowner_ra, mlink_ra;
   logic [EW-1:0] ohead_wa, otail_wa, occ_ra;
   logic [SL-1:0] bh_wd, sprev_wd, snext_wd, mowner_wd;
   logic [CW-1:0] sscore_wd;
   logic [ML-1:0] sfirst_wd, slast_wd, mprev_wd, mnext_wd, onext_wd, ohead_wd, otail_wd;
   logic [EW-1:0] melem_wd;
   logic          sused_wd;

   logic [SL-1:0] bh_rd_ff, sprev_rd_ff, snext_rd_ff, mowner_rd_ff;
   logic [CW-1:0] sscore_rd_ff;
   logic [ML-1:0] sfirst_rd_ff, slast_rd_ff, mprev_rd_ff, mnext_rd_ff;
   logic [ML-1:0] onext_rd_ff, ohead_rd_ff, otail_rd_ff;
   logic [EW-1:0] melem_rd_ff;
   logic          sused_rd_ff;

   // effective limits
   logic [31:0] eff_score, eff_cap;
   logic        set_bad, score_bad, elem_bad;

   always_comb begin
      eff_score = (32'(score_limit_ff) < 32'(MAX_SCORE)) ? 32'(score_limit_ff)
                                                        : 32'(MAX_SCORE);
      eff_cap   = (32'(member_cap_ff) < 32'(MAX_MEMBERS)) ? 32'(member_cap_ff)
                                                         : 32'(MAX_MEMBERS);
      set_bad   = (32'(req_ff.set_number) > 32'(set_limit_ff))
               || (32'(req_ff.set_number) >= 32'(MAX_SETS)) || sused_rd_ff;
      score_bad = 32'(req_ff.set_score) > eff_score;
      elem_bad  = (32'(req_ff.element_number) > 32'(elem_limit_ff))
               || (32'(req_ff.element_number) >= 32'(MAX_ELEMENT_IDS));
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      logic [SW-1:0] rq_set;
      logic [CW-1:0] rq_sc;
      logic [SL-1:0] p_lk, n_lk;
      logic [ML-1:0] mp_lk, mn_lk;
      rq_set = SW'(32'(req_ff.set_number));
      rq_sc  = CW'(32'(req_ff.set_score));
      p_lk   = sprev_rd_ff;
      n_lk   = snext_rd_ff;
      mp_lk  = mprev_rd_ff;
      mn_lk  = mnext_rd_ff;

      state_in = state_ff;  clr_in = clr_ff;
      score_limit_in = score_limit_ff;  set_limit_in = set_limit_ff;
      elem_limit_in = elem_limit_ff;    member_cap_in = member_cap_ff;
      scan_in = scan_ff;  open_in = open_ff;  fill_in = fill_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_in = rsp_ff;  res_in = res_ff;
      req_in = req_ff;  s_in = s_ff;  x_in = x_ff;  h_in = h_ff;  sc_in = sc_ff;
      m_in = m_ff;  mn_in = mn_ff;  o_in = o_ff;  on_in = on_ff;
      own_in = own_ff;  pick_in = pick_ff;

      bh_we = 1'b0; sprev_we = 1'b0; snext_we = 1'b0; sscore_we = 1'b0;
      sfirst_we = 1'b0; slast_we = 1'b0; sused_we = 1'b0; melem_we = 1'b0;
      mowner_we = 1'b0; mprev_we = 1'b0; mnext_we = 1'b0; onext_we = 1'b0;
      ohead_we = 1'b0; otail_we = 1'b0;
      bh_re = 1'b0; sprev_re = 1'b0; snext_re = 1'b0; sscore_re = 1'b0;
      sfirst_re = 1'b0; slast_re = 1'b0; sused_re = 1'b0; melem_re = 1'b0;
      mowner_re = 1'b0; mprev_re = 1'b0; mnext_re = 1'b0; onext_re = 1'b0;
      ohead_re = 1'b0; otail_re = 1'b0;
      bh_wa = '0; bh_ra = '0; sprev_wa = '0; snext_wa = '0; sscore_wa = '0;
      sfirst_wa = '0; slast_wa = '0; sused_wa = '0; set_ra = '0; sfirst_ra = '0;
      slast_ra = '0; sused_ra = '0; melem_wa = '0; mowner_wa = '0; mprev_wa = '0;
      mnext_wa = '0; onext_wa = '0; mem_ra = '0; mowner_ra = '0; mlink_ra = '0;
      ohead_wa = '0; otail_wa = '0; occ_ra = '0;
      bh_wd = '0; sprev_wd = '0; snext_wd = '0; mowner_wd = '0; sscore_wd = '0;
      sfirst_wd = '0; slast_wd = '0; mprev_wd = '0; mnext_wd = '0; onext_wd = '0;
      ohead_wd = '0; otail_wd = '0; melem_wd = '0; sused_wd = 1'b0;

      // drain the result register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // sweep bucket heads, used flags and occurrence heads
            bh_we    = 32'(clr_ff) <= 32'(MAX_SCORE);
            bh_wa    = CW'(clr_ff);
            bh_wd    = SET_NIL;
            sused_we = 32'(clr_ff) < 32'(MAX_SETS);
            sused_wa = SW'(clr_ff);
            ohead_we = 32'(clr_ff) < 32'(MAX_ELEMENT_IDS);
            ohead_wa = EW'(clr_ff);
            ohead_wd = MEM_NIL;
            clr_in   = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
               case (req_data.kind)
                  gsc_pkg::KIND_OPEN: begin
                     sused_re = 1'b1;
                     sused_ra = SW'(32'(req_data.set_number));
                     bh_re    = 1'b1;
                     bh_ra    = CW'(32'(req_data.set_score));
                     state_in = S_OPEN;
                  end
                  gsc_pkg::KIND_MEMBER: begin
                     slast_re = 1'b1;
                     slast_ra = open_ff[SW-1:0];
                     ohead_re = 1'b1;
                     otail_re = 1'b1;
                     occ_ra   = EW'(32'(req_data.element_number));
                     state_in = S_MEM;
                  end
                  gsc_pkg::KIND_PICK: begin
                     open_in  = SET_NIL;
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_OPEN: begin
            if (set_bad) begin
               res_in.status = gsc_pkg::ST_BAD_SET;
               state_in = S_RESULT;
            end else if (score_bad) begin
               res_in.status = gsc_pkg::ST_BAD_SCORE;
               state_in = S_RESULT;
            end else begin
               // record the set and push it at the head of its bucket
               sused_we  = 1'b1; sused_wa = rq_set; sused_wd = 1'b1;
               sscore_we = 1'b1; sscore_wa = rq_set; sscore_wd = rq_sc;
               sfirst_we = 1'b1; sfirst_wa = rq_set; sfirst_wd = MEM_NIL;
               slast_we  = 1'b1; slast_wa = rq_set; slast_wd = MEM_NIL;
               snext_we  = 1'b1; snext_wa = rq_set; snext_wd = bh_rd_ff;
               sprev_we  = 1'b1; sprev_wa = rq_set; sprev_wd = SET_NIL;
               bh_we     = 1'b1; bh_wa = rq_sc; bh_wd = SL'(rq_set);
               if (rq_sc > scan_ff) begin
                  scan_in = rq_sc;
               end
               open_in  = SL'(rq_set);
               x_in     = rq_set;
               h_in     = bh_rd_ff;
               pick_in  = 1'b0;
               state_in = bh_rd_ff[SW] ? S_RESULT : S_LINK;
            end
         end
         S_LINK: begin
            // back link of the former bucket head
            sprev_we = 1'b1;
            sprev_wa = h_ff[SW-1:0];
            sprev_wd = SL'(x_ff);
            state_in = pick_ff ? S_O_NEXT : S_RESULT;
         end
         S_MEM: begin
            if (open_ff[SW]) begin
               res_in.status = gsc_pkg::ST_BAD_SET;
               state_in = S_RESULT;
            end else if (32'(fill_ff) >= eff_cap) begin
               res_in.status = gsc_pkg::ST_OVERFLOW;
               state_in = S_RESULT;
            end else if (elem_bad) begin
               res_in.status = gsc_pkg::ST_BAD_ELEM;
               state_in = S_RESULT;
            end else if (req_ff.member_weight != gsc_pkg::UNIT_WEIGHT) begin
               res_in.status = gsc_pkg::ST_BAD_WEIGHT;
               state_in = S_RESULT;
            end else begin
               // write the new membership and the list tails
               melem_we  = 1'b1; melem_wa = fill_ff[MW-1:0];
               melem_wd  = EW'(32'(req_ff.element_number));
               mowner_we = 1'b1; mowner_wa = fill_ff[MW-1:0]; mowner_wd = open_ff;
               mprev_we  = 1'b1; mprev_wa = fill_ff[MW-1:0]; mprev_wd = slast_rd_ff;
               mnext_we  = 1'b1; mnext_wa = fill_ff[MW-1:0]; mnext_wd = MEM_NIL;
               onext_we  = 1'b1; onext_wa = fill_ff[MW-1:0]; onext_wd = MEM_NIL;
               slast_we  = 1'b1; slast_wa = open_ff[SW-1:0]; slast_wd = fill_ff;
               otail_we  = 1'b1; otail_wa = EW'(32'(req_ff.element_number));
               otail_wd  = fill_ff;
               ohead_we  = ohead_rd_ff[MW];
               ohead_wa  = EW'(32'(req_ff.element_number));
               ohead_wd  = fill_ff;
               sfirst_we = slast_rd_ff[MW];
               sfirst_wa = open_ff[SW-1:0];
               sfirst_wd = fill_ff;
               m_in      = fill_ff;
               fill_in   = fill_ff + 1'b1;
               state_in  = S_MEM_LNK;
            end
         end
         S_MEM_LNK: begin
            // forward links from the previous member and occurrence
            mnext_we = !slast_rd_ff[MW];
            mnext_wa = slast_rd_ff[MW-1:0];
            mnext_wd = m_ff;
            onext_we = !ohead_rd_ff[MW];
            onext_wa = otail_rd_ff[MW-1:0];
            onext_wd = m_ff;
            state_in = S_RESULT;
         end
         S_SCAN: begin
            if (scan_ff == '0) begin
               res_in.cover_done = 1'b1;
               state_in = S_RESULT;
            end else begin
               bh_re    = 1'b1;
               bh_ra    = scan_ff;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (bh_rd_ff[SW]) begin
               scan_in  = scan_ff - 1'b1;
               state_in = S_SCAN;
            end else begin
               s_in      = bh_rd_ff[SW-1:0];
               x_in      = bh_rd_ff[SW-1:0];
               sprev_re  = 1'b1; snext_re = 1'b1; sscore_re = 1'b1;
               set_ra    = bh_rd_ff[SW-1:0];
               own_in    = 1'b1;
               state_in  = S_UNP;
            end
         end
         S_UNP: begin
            // unplug the set from its bucket list
            bh_we    = p_lk[SW];
            bh_wa    = sscore_rd_ff;
            bh_wd    = n_lk;
            snext_we = !p_lk[SW];
            snext_wa = p_lk[SW-1:0];
            snext_wd = n_lk;
            sprev_we = !n_lk[SW];
            sprev_wa = n_lk[SW-1:0];
            sprev_wd = p_lk;
            if (own_ff) begin
               sfirst_re = 1'b1;
               sfirst_ra = s_ff;
               state_in  = S_FIRST;
            end else begin
               sc_in     = (sscore_rd_ff == '0) ? sscore_rd_ff : sscore_rd_ff - 1'b1;
               sscore_we = 1'b1;
               sscore_wa = x_ff;
               sscore_wd = (sscore_rd_ff == '0) ? sscore_rd_ff : sscore_rd_ff - 1'b1;
               state_in  = S_UNL;
            end
         end
         S_UNL: begin
            // unlink the occurrence from its owner's member list
            sfirst_we = mp_lk[MW];
            sfirst_wa = x_ff;
            sfirst_wd = mn_lk;
            mnext_we  = !mp_lk[MW];
            mnext_wa  = mp_lk[MW-1:0];
            mnext_wd  = mn_lk;
            slast_we  = mn_lk[MW];
            slast_wa  = x_ff;
            slast_wd  = mp_lk;
            mprev_we  = !mn_lk[MW];
            mprev_wa  = mn_lk[MW-1:0];
            mprev_wd  = mp_lk;
            mowner_we = 1'b1;
            mowner_wa = o_ff[MW-1:0];
            mowner_wd = SET_NIL;
            bh_re     = 1'b1;
            bh_ra     = sc_ff;
            state_in  = S_PUSH;
         end
         S_PUSH: begin
            // push the owner at the head of its new bucket
            snext_we = 1'b1; snext_wa = x_ff; snext_wd = bh_rd_ff;
            sprev_we = 1'b1; sprev_wa = x_ff; sprev_wd = SET_NIL;
            bh_we    = 1'b1; bh_wa = sc_ff; bh_wd = SL'(x_ff);
            h_in     = bh_rd_ff;
            pick_in  = 1'b1;
            state_in = bh_rd_ff[SW] ? S_O_NEXT : S_LINK;
         end
         S_FIRST: begin
            m_in     = sfirst_rd_ff;
            state_in = S_M;
         end
         S_M: begin
            if (m_ff[MW]) begin
               res_in.picked_set   = 10'(32'(s_ff));
               res_in.picked_valid = 1'b1;
               state_in = S_RESULT;
            end else begin
               melem_re = 1'b1;
               mnext_re = 1'b1;
               mem_ra   = m_ff[MW-1:0];
               state_in = S_M_RD;
            end
         end
         S_M_RD: begin
            mn_in    = mnext_rd_ff;
            ohead_re = 1'b1;
            occ_ra   = melem_rd_ff;
            state_in = S_O_HEAD;
         end
         S_O_HEAD: begin
            o_in     = ohead_rd_ff;
            state_in = S_O;
         end
         S_O: begin
            if (o_ff[MW]) begin
               // drop ownership of the picked member and advance
               mowner_we = 1'b1;
               mowner_wa = m_ff[MW-1:0];
               mowner_wd = SET_NIL;
               m_in      = mn_ff;
               state_in  = S_M;
            end else begin
               mowner_re = 1'b1;
               onext_re  = 1'b1;
               mowner_ra = o_ff[MW-1:0];
               state_in  = S_O_CHK;
            end
         end
         S_O_CHK: begin
            on_in = onext_rd_ff;
            if (!mowner_rd_ff[SW] && (mowner_rd_ff[SW-1:0] != s_ff)) begin
               x_in      = mowner_rd_ff[SW-1:0];
               sprev_re  = 1'b1; snext_re = 1'b1; sscore_re = 1'b1;
               set_ra    = mowner_rd_ff[SW-1:0];
               mprev_re  = 1'b1; mnext_re = 1'b1;
               mlink_ra  = o_ff[MW-1:0];
               own_in    = 1'b0;
               state_in  = S_UNP;
            end else begin
               o_in     = onext_rd_ff;
               state_in = S_O;
            end
         end
         S_O_NEXT: begin
            o_in     = on_ff;
            state_in = S_O;
         end
         S_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            gsc_pkg::CSR_SCORE_LIMIT: begin
               score_limit_in = csr_data[7:0];
               scan_in = (32'(csr_data[7:0]) < 32'(MAX_SCORE)) ? CW'(32'(csr_data[7:0]))
                                                             : CW'(32'(MAX_SCORE));
            end
            gsc_pkg::CSR_SET_LIMIT:  set_limit_in  = csr_data[9:0];
            gsc_pkg::CSR_ELEM_LIMIT: elem_limit_in = csr_data[11:0];
            gsc_pkg::CSR_MEMBER_CAP: member_cap_in = csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         score_limit_ff <= gsc_pkg::RST_SCORE_LIMIT;
         set_limit_ff   <= gsc_pkg::RST_SET_LIMIT;
         elem_limit_ff  <= gsc_pkg::RST_ELEM_LIMIT;
         member_cap_ff  <= gsc_pkg::RST_MEMBER_CAP;
         scan_ff        <= (32'(gsc_pkg::RST_SCORE_LIMIT) < 32'(MAX_SCORE))
                           ? CW'(32'(gsc_pkg::RST_SCORE_LIMIT)) : CW'(32'(MAX_SCORE));
         open_ff        <= SET_NIL;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         score_limit_ff <= score_limit_in;
         set_limit_ff   <= set_limit_in;
         elem_limit_ff  <= elem_limit_in;
         member_cap_ff  <= member_cap_in;
         scan_ff        <= scan_in;
         open_ff        <= open_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      res_ff  <= res_in;
      req_ff  <= req_in;
      s_ff    <= s_in;
      x_ff    <= x_in;
      h_ff    <= h_in;
      sc_ff   <= sc_in;
      m_ff    <= m_in;
      mn_ff   <= mn_in;
      o_ff    <= o_in;
      on_ff   <= on_in;
      own_ff  <= own_in;
      pick_ff <= pick_in;
   end

   // bucket heads
   always_ff @(posedge clock) begin
      if (bh_we) bh_mem[bh_wa] <= bh_wd;
      if (bh_re) bh_rd_ff <= bh_mem[bh_ra];
   end

   // per-set stores
   always_ff @(posedge clock) begin
      if (sprev_we) sprev_mem[sprev_wa] <= sprev_wd;
      if (sprev_re) sprev_rd_ff <= sprev_mem[set_ra];
   end
   always_ff @(posedge clock) begin
      if (snext_we) snext_mem[snext_wa] <= snext_wd;
      if (snext_re) snext_rd_ff <= snext_mem[set_ra];
   end
   always_ff @(posedge clock) begin
      if (sscore_we) sscore_mem[sscore_wa] <= sscore_wd;
      if (sscore_re) sscore_rd_ff <= sscore_mem[set_ra];
   end
   always_ff @(posedge clock) begin
      if (sfirst_we) sfirst_mem[sfirst_wa] <= sfirst_wd;
      if (sfirst_re) sfirst_rd_ff <= sfirst_mem[sfirst_ra];
   end
   always_ff @(posedge clock) begin
      if (slast_we) slast_mem[slast_wa] <= slast_wd;
      if (slast_re) slast_rd_ff <= slast_mem[slast_ra];
   end
   always_ff @(posedge clock) begin
      if (sused_we) sused_mem[sused_wa] <= sused_wd;
      if (sused_re) sused_rd_ff <= sused_mem[sused_ra];
   end

   // per-membership stores
   always_ff @(posedge clock) begin
      if (melem_we) melem_mem[melem_wa] <= melem_wd;
      if (melem_re) melem_rd_ff <= melem_mem[mem_ra];
   end
   always_ff @(posedge clock) begin
      if (mowner_we) mowner_mem[mowner_wa] <= mowner_wd;
      if (mowner_re) mowner_rd_ff <= mowner_mem[mowner_ra];
   end
   always_ff @(posedge clock) begin
      if (mprev_we) mprev_mem[mprev_wa] <= mprev_wd;
      if (mprev_re) mprev_rd_ff <= mprev_mem[mlink_ra];
   end
   always_ff @(posedge clock) begin
      if (mnext_we) mnext_mem[mnext_wa] <= mnext_wd;
      if (mnext_re) mnext_rd_ff <= mnext_mem[(state_ff == S_M) ? mem_ra : mlink_ra];
   end
   always_ff @(posedge clock) begin
      if (onext_we) onext_mem[onext_wa] <= onext_wd;
      if (onext_re) onext_rd_ff <= onext_mem[mowner_ra];
   end

   // per-element occurrence lists
   always_ff @(posedge clock) begin
      if (ohead_we) ohead_mem[ohead_wa] <= ohead_wd;
      if (ohead_re) ohead_rd_ff <= ohead_mem[occ_ra];
   end
   always_ff @(posedge clock) begin
      if (otail_we) otail_mem[otail_wa] <= otail_wd;
      if (otail_re) otail_rd_ff <= otail_mem[occ_ra];
   end

endmodule

`default_nettype wire
